// ===== hw/rtl/first_fit_block_allocator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit block allocator
// Shared concurrent-assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define FFBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ffba check failed");

// next-cycle implication
`define FFBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ffba check failed");

`endif

// ===== hw/rtl/ffba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg
// Types, codes and defaults shared by the allocator modules.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int POOL_COUNT_DEF = 4;
	localparam int ENTRIES_DEF    = 32;
	localparam int ADDR_BITS_DEF  = 20;

	localparam int KIND_W  = 2;
	localparam int POOL_W  = 2;
	localparam int BYTES_W = 21;
	localparam int OFF_W   = 20;
	localparam int STS_W   = 2;
	localparam int REQ_W   = 22;
	localparam int CFG_IDX_W = 2;

	localparam logic [REQ_W-1:0] ALIGN_LOW = REQ_W'(7);
	localparam logic [33:0] HEAP_RESET = 34'd65536;
	localparam logic [33:0] HEAP_MIN   = 34'd8;
	localparam int ENTRIES_MIN = 2;
	localparam int ENTRIES_RESET_CAP = 32;

	localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RESIZE  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NONE    = 2'd3;

	localparam logic [STS_W-1:0] STS_OK       = 2'd0;
	localparam logic [STS_W-1:0] STS_NOFIT    = 2'd1;
	localparam logic [STS_W-1:0] STS_NOTFOUND = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_HEAP_BYTES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRIES    = 2'd1;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DECODE, ST_SCAN_RD, ST_SCAN_EV, ST_FIND_DONE, ST_GR_EV, ST_GR_ZB,
		ST_SP_START, ST_SP_WS, ST_SP_WA, ST_SP_RET, ST_PV_RD, ST_PV_WR, ST_RR_RD,
		ST_RR_EV, ST_REL_START, ST_REL_N_EV, ST_REL_ZB, ST_REL_WA, ST_REL_P_EV,
		ST_REL_WB, ST_REL_ZA, ST_REL_RET, ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		CTX_ALLOC, CTX_MOVE, CTX_SHRINK, CTX_GROW, CTX_FREE
	} ctx_t;

	typedef enum logic [1:0] {
		SC_FIT, SC_FIND, SC_SPARE
	} scan_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [POOL_W-1:0]  pool;
		logic [BYTES_W-1:0] request_bytes;
		logic [OFF_W-1:0]   block_offset;
		logic               offset_present;
	} req_t;

	typedef struct packed {
		logic [STS_W-1:0]   status;
		logic [OFF_W-1:0]   result_offset;
		logic               result_present;
		logic               moved;
		logic [OFF_W-1:0]   old_offset;
		logic [BYTES_W-1:0] copy_bytes;
	} rsp_t;

endpackage

// ===== hw/rtl/ffba_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/ffba_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_core
// Segment table sequencer: scans, split, merge and release over the table RAM.
// ----------------------------------------------------------------------------
module ffba_core #(
	parameter int POOL_COUNT = ffba_pkg::POOL_COUNT_DEF,
	parameter int ENTRIES    = ffba_pkg::ENTRIES_DEF,
	parameter int AW         = ffba_pkg::ADDR_BITS_DEF,
	parameter int EIW        = $clog2(ENTRIES + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  ffba_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output ffba_pkg::rsp_t  rsp,
	input  logic [AW:0]     heap,
	input  logic [EIW-1:0]  eiu,
	input  logic            reinit
);

	localparam int IW    = $clog2(ENTRIES);
	localparam int PW    = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
	localparam int RAW   = PW + IW;
	localparam int DEPTH = 1 << RAW;
	localparam int CMPW  = ((AW + 1) > ffba_pkg::REQ_W) ? AW + 2 : ffba_pkg::REQ_W + 1;
	localparam int EW    = AW + (AW + 1) + 4 + 2 * IW;

	typedef struct packed {
		logic [AW-1:0] off;
		logic [AW:0]   size;
		logic          used;
		logic          present;
		logic          has_prev;
		logic          has_next;
		logic [IW-1:0] prev;
		logic [IW-1:0] next;
	} ent_t;

	ffba_pkg::state_t state_q, state_d, ret_q, ret_d;
	ffba_pkg::ctx_t   ctx_q, ctx_d;
	ffba_pkg::scan_t  scan_q, scan_d;

	logic [EIW-1:0] idx_q, idx_d;
	logic [ffba_pkg::KIND_W-1:0] kind_q, kind_d;
	logic [PW-1:0] pool_q, pool_d;
	logic [ffba_pkg::REQ_W-1:0] req_q, req_d;
	logic [ffba_pkg::OFF_W-1:0] boff_q, boff_d;
	logic given_q, given_d, bzero_q, bzero_d;
	ent_t a_q, a_d, b_q, b_d;
	logic [IW-1:0] ai_q, ai_d, bi_q, bi_d, oi_q, oi_d, pv_tgt_q, pv_tgt_d, pv_val_q, pv_val_d;
	logic [AW-1:0] res_off_q, res_off_d, old_off_q, old_off_d;
	logic [AW:0] old_size_q, old_size_d;
	logic sp_used_q, sp_used_d, sp_hit_q, sp_hit_d;
	logic [ffba_pkg::STS_W-1:0] sts_q, sts_d;
	logic pres_q, pres_d, moved_q, moved_d;

	logic [DEPTH-1:0] vld_q;
	logic rd_vld_q, rd_idx0_q;
	logic [IW-1:0] rd_idx;
	logic wr_en;
	logic [IW-1:0] wr_idx;
	ent_t wr_ent, rd_ent, ram_ent, init_ent;
	logic [EW-1:0] ram_rdata;
	logic [4:0] pm;
	logic hit;
	logic [ffba_pkg::REQ_W-1:0] req_rnd;

	ffba_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr ({pool_q, wr_idx}),
		.wdata (wr_ent),
		.raddr ({pool_q, rd_idx}),
		.rdata (ram_rdata)
	);

	// entries never written since reset or a register write read as the initial table
	always_comb begin
		ram_ent = ram_rdata;
		init_ent = '0;
		init_ent.present = 1'b1;
		init_ent.size = heap;
		if (rd_vld_q) begin
			rd_ent = ram_ent;
		end else if (rd_idx0_q) begin
			rd_ent = init_ent;
		end else begin
			rd_ent = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_q <= 1'b0;
			rd_idx0_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[{pool_q, rd_idx}];
			rd_idx0_q <= (rd_idx == '0);
			if (reinit) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[{pool_q, wr_idx}] <= 1'b1;
			end
		end
	end

	always_comb begin
		pm = 5'(req.pool);
		for (int k = 0; k < 3; k++) begin
			if (pm >= 5'(POOL_COUNT)) begin
				pm = pm - 5'(POOL_COUNT);
			end
		end
		req_rnd = (ffba_pkg::REQ_W'(req.request_bytes) + ffba_pkg::ALIGN_LOW)
			& ~ffba_pkg::ALIGN_LOW;
	end

	always_comb begin
		state_d = state_q; ret_d = ret_q; ctx_d = ctx_q; scan_d = scan_q;
		idx_d = idx_q; kind_d = kind_q; pool_d = pool_q; req_d = req_q;
		boff_d = boff_q; given_d = given_q; bzero_d = bzero_q;
		a_d = a_q; b_d = b_q; ai_d = ai_q; bi_d = bi_q; oi_d = oi_q;
		pv_tgt_d = pv_tgt_q; pv_val_d = pv_val_q;
		res_off_d = res_off_q; old_off_d = old_off_q; old_size_d = old_size_q;
		sp_used_d = sp_used_q; sp_hit_d = sp_hit_q;
		sts_d = sts_q; pres_d = pres_q; moved_d = moved_q;
		wr_en = 1'b0; wr_idx = ai_q; wr_ent = a_q; rd_idx = ai_q;
		req_ready = 1'b0; rsp_valid = 1'b0; hit = 1'b0;
		case (state_q)
			ffba_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					kind_d = req.kind;
					pool_d = pm[PW-1:0];
					req_d = req_rnd;
					boff_d = req.block_offset;
					given_d = req.offset_present;
					bzero_d = (req.request_bytes == '0);
					sts_d = ffba_pkg::STS_OK; pres_d = 1'b0; moved_d = 1'b0;
					state_d = ffba_pkg::ST_DECODE;
				end
			end
			ffba_pkg::ST_DECODE: begin
				idx_d = '0;
				if (kind_q == ffba_pkg::KIND_NONE
						|| (kind_q == ffba_pkg::KIND_RELEASE && !given_q)) begin
					state_d = ffba_pkg::ST_EMIT;
				end else if (kind_q == ffba_pkg::KIND_ALLOC || !given_q) begin
					if (bzero_q) begin
						state_d = ffba_pkg::ST_EMIT;
					end else begin
						ctx_d = ffba_pkg::CTX_ALLOC; scan_d = ffba_pkg::SC_FIT;
						state_d = ffba_pkg::ST_SCAN_RD;
					end
				end else begin
					scan_d = ffba_pkg::SC_FIND;
					state_d = ffba_pkg::ST_SCAN_RD;
				end
			end
			ffba_pkg::ST_SCAN_RD: begin
				rd_idx = idx_q[IW-1:0];
				state_d = ffba_pkg::ST_SCAN_EV;
			end
			ffba_pkg::ST_SCAN_EV: begin
				case (scan_q)
					ffba_pkg::SC_FIT: hit = rd_ent.present && !rd_ent.used
						&& (CMPW'(rd_ent.size) >= CMPW'(req_q));
					ffba_pkg::SC_FIND: hit = rd_ent.present && rd_ent.used
						&& (CMPW'(rd_ent.off) == CMPW'(boff_q));
					default: hit = !rd_ent.present;
				endcase
				if (hit) begin
					case (scan_q)
						ffba_pkg::SC_FIT: begin
							a_d = rd_ent; ai_d = idx_q[IW-1:0]; res_off_d = rd_ent.off;
							sp_used_d = 1'b1;
							state_d = ffba_pkg::ST_SP_START;
						end
						ffba_pkg::SC_FIND: begin
							a_d = rd_ent; ai_d = idx_q[IW-1:0]; oi_d = idx_q[IW-1:0];
							res_off_d = rd_ent.off; old_off_d = rd_ent.off;
							old_size_d = rd_ent.size;
							state_d = ffba_pkg::ST_FIND_DONE;
						end
						default: begin
							bi_d = idx_q[IW-1:0];
							state_d = ffba_pkg::ST_SP_WS;
						end
					endcase
				end else if ((EIW + 1)'(idx_q) + (EIW + 1)'(1) >= (EIW + 1)'(eiu)) begin
					case (scan_q)
						ffba_pkg::SC_FIT: begin
							sts_d = ffba_pkg::STS_NOFIT;
							state_d = ffba_pkg::ST_EMIT;
						end
						ffba_pkg::SC_FIND: begin
							sts_d = ffba_pkg::STS_NOTFOUND;
							state_d = ffba_pkg::ST_EMIT;
						end
						default: begin
							wr_en = 1'b1;
							wr_ent.used = sp_used_q;
							sp_hit_d = 1'b0;
							state_d = ffba_pkg::ST_SP_RET;
						end
					endcase
				end else begin
					idx_d = idx_q + EIW'(1);
					state_d = ffba_pkg::ST_SCAN_RD;
				end
			end
			ffba_pkg::ST_FIND_DONE: begin
				idx_d = '0;
				if (kind_q == ffba_pkg::KIND_RELEASE || bzero_q) begin
					ctx_d = ffba_pkg::CTX_FREE;
					state_d = ffba_pkg::ST_REL_START;
				end else if (CMPW'(req_q) < CMPW'(a_q.size)) begin
					ctx_d = ffba_pkg::CTX_SHRINK; sp_used_d = 1'b1;
					state_d = ffba_pkg::ST_SP_START;
				end else if (CMPW'(req_q) == CMPW'(a_q.size)) begin
					pres_d = 1'b1;
					state_d = ffba_pkg::ST_EMIT;
				end else if (a_q.has_next) begin
					rd_idx = a_q.next;
					state_d = ffba_pkg::ST_GR_EV;
				end else begin
					ctx_d = ffba_pkg::CTX_MOVE; scan_d = ffba_pkg::SC_FIT;
					state_d = ffba_pkg::ST_SCAN_RD;
				end
			end
			ffba_pkg::ST_GR_EV: begin
				if (rd_ent.present && !rd_ent.used
						&& CMPW'(req_q) <= CMPW'(a_q.size) + CMPW'(rd_ent.size)) begin
					a_d.size = (AW + 1)'(CMPW'(a_q.size) + CMPW'(rd_ent.size));
					a_d.has_next = rd_ent.has_next;
					a_d.next = rd_ent.next;
					bi_d = a_q.next;
					if (rd_ent.has_next) begin
						pv_tgt_d = rd_ent.next; pv_val_d = ai_q;
						ret_d = ffba_pkg::ST_GR_ZB;
						state_d = ffba_pkg::ST_PV_RD;
					end else begin
						state_d = ffba_pkg::ST_GR_ZB;
					end
				end else begin
					ctx_d = ffba_pkg::CTX_MOVE; scan_d = ffba_pkg::SC_FIT;
					state_d = ffba_pkg::ST_SCAN_RD;
				end
			end
			ffba_pkg::ST_GR_ZB: begin
				wr_en = 1'b1; wr_idx = bi_q; wr_ent = '0;
				ctx_d = ffba_pkg::CTX_GROW; sp_used_d = 1'b1;
				state_d = ffba_pkg::ST_SP_START;
			end
			ffba_pkg::ST_SP_START: begin
				idx_d = '0;
				if (CMPW'(a_q.size) > CMPW'(req_q)) begin
					scan_d = ffba_pkg::SC_SPARE;
					state_d = ffba_pkg::ST_SCAN_RD;
				end else begin
					wr_en = 1'b1;
					wr_ent.used = sp_used_q;
					sp_hit_d = 1'b0;
					state_d = ffba_pkg::ST_SP_RET;
				end
			end
			ffba_pkg::ST_SP_WS: begin
				wr_en = 1'b1; wr_idx = bi_q;
				wr_ent.off = AW'(CMPW'(a_q.off) + CMPW'(req_q));
				wr_ent.size = (AW + 1)'(CMPW'(a_q.size) - CMPW'(req_q));
				wr_ent.used = 1'b0;
				wr_ent.present = 1'b1;
				wr_ent.has_prev = 1'b1;
				wr_ent.prev = ai_q;
				wr_ent.has_next = a_q.has_next;
				wr_ent.next = a_q.next;
				b_d = wr_ent;
				if (a_q.has_next) begin
					pv_tgt_d = a_q.next; pv_val_d = bi_q;
					ret_d = ffba_pkg::ST_SP_WA;
					state_d = ffba_pkg::ST_PV_RD;
				end else begin
					state_d = ffba_pkg::ST_SP_WA;
				end
			end
			ffba_pkg::ST_SP_WA: begin
				wr_en = 1'b1;
				wr_ent.has_next = 1'b1;
				wr_ent.next = bi_q;
				wr_ent.size = (AW + 1)'(req_q);
				wr_ent.used = sp_used_q;
				sp_hit_d = 1'b1;
				state_d = ffba_pkg::ST_SP_RET;
			end
			ffba_pkg::ST_SP_RET: begin
				case (ctx_q)
					ffba_pkg::CTX_MOVE: state_d = ffba_pkg::ST_RR_RD;
					ffba_pkg::CTX_SHRINK, ffba_pkg::CTX_GROW: begin
						if (sp_hit_q) begin
							a_d = b_q; ai_d = bi_q;
							state_d = ffba_pkg::ST_REL_START;
						end else begin
							pres_d = 1'b1;
							state_d = ffba_pkg::ST_EMIT;
						end
					end
					default: begin
						pres_d = 1'b1;
						state_d = ffba_pkg::ST_EMIT;
					end
				endcase
			end
			ffba_pkg::ST_PV_RD: begin
				rd_idx = pv_tgt_q;
				state_d = ffba_pkg::ST_PV_WR;
			end
			ffba_pkg::ST_PV_WR: begin
				wr_en = 1'b1; wr_idx = pv_tgt_q;
				wr_ent = rd_ent;
				wr_ent.prev = pv_val_q;
				state_d = ret_q;
			end
			ffba_pkg::ST_RR_RD: begin
				rd_idx = oi_q;
				state_d = ffba_pkg::ST_RR_EV;
			end
			ffba_pkg::ST_RR_EV: begin
				a_d = rd_ent; ai_d = oi_q;
				state_d = ffba_pkg::ST_REL_START;
			end
			ffba_pkg::ST_REL_START: begin
				a_d.used = 1'b0;
				if (a_q.has_next) begin
					rd_idx = a_q.next;
					state_d = ffba_pkg::ST_REL_N_EV;
				end else begin
					state_d = ffba_pkg::ST_REL_WA;
				end
			end
			ffba_pkg::ST_REL_N_EV: begin
				if (rd_ent.present && !rd_ent.used) begin
					a_d.size = (AW + 1)'(CMPW'(a_q.size) + CMPW'(rd_ent.size));
					a_d.has_next = rd_ent.has_next;
					a_d.next = rd_ent.next;
					bi_d = a_q.next;
					if (rd_ent.has_next) begin
						pv_tgt_d = rd_ent.next; pv_val_d = ai_q;
						ret_d = ffba_pkg::ST_REL_ZB;
						state_d = ffba_pkg::ST_PV_RD;
					end else begin
						state_d = ffba_pkg::ST_REL_ZB;
					end
				end else begin
					state_d = ffba_pkg::ST_REL_WA;
				end
			end
			ffba_pkg::ST_REL_ZB: begin
				wr_en = 1'b1; wr_idx = bi_q; wr_ent = '0;
				state_d = ffba_pkg::ST_REL_WA;
			end
			ffba_pkg::ST_REL_WA: begin
				wr_en = 1'b1;
				if (a_q.has_prev) begin
					rd_idx = a_q.prev;
					state_d = ffba_pkg::ST_REL_P_EV;
				end else begin
					state_d = ffba_pkg::ST_REL_RET;
				end
			end
			ffba_pkg::ST_REL_P_EV: begin
				if (rd_ent.present && !rd_ent.used) begin
					b_d = rd_ent;
					b_d.size = (AW + 1)'(CMPW'(rd_ent.size) + CMPW'(a_q.size));
					b_d.has_next = a_q.has_next;
					b_d.next = a_q.next;
					bi_d = a_q.prev;
					if (a_q.has_next) begin
						pv_tgt_d = a_q.next; pv_val_d = a_q.prev;
						ret_d = ffba_pkg::ST_REL_WB;
						state_d = ffba_pkg::ST_PV_RD;
					end else begin
						state_d = ffba_pkg::ST_REL_WB;
					end
				end else begin
					state_d = ffba_pkg::ST_REL_RET;
				end
			end
			ffba_pkg::ST_REL_WB: begin
				wr_en = 1'b1; wr_idx = bi_q; wr_ent = b_q;
				state_d = ffba_pkg::ST_REL_ZA;
			end
			ffba_pkg::ST_REL_ZA: begin
				wr_en = 1'b1; wr_ent = '0;
				state_d = ffba_pkg::ST_REL_RET;
			end
			ffba_pkg::ST_REL_RET: begin
				case (ctx_q)
					ffba_pkg::CTX_FREE: pres_d = 1'b0;
					ffba_pkg::CTX_MOVE: begin
						pres_d = 1'b1; moved_d = 1'b1;
					end
					default: pres_d = 1'b1;
				endcase
				state_d = ffba_pkg::ST_EMIT;
			end
			ffba_pkg::ST_EMIT: begin
				rsp_valid = 1'b1;
				if (rsp_ready) begin
					state_d = ffba_pkg::ST_IDLE;
				end
			end
			default: state_d = ffba_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		rsp.status = sts_q;
		rsp.result_present = pres_q;
		rsp.moved = moved_q;
		rsp.result_offset = pres_q ? ffba_pkg::OFF_W'(CMPW'(res_off_q)) : '0;
		rsp.old_offset = moved_q ? ffba_pkg::OFF_W'(CMPW'(old_off_q)) : '0;
		rsp.copy_bytes = moved_q ? ffba_pkg::BYTES_W'(CMPW'(old_size_q)) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffba_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		ret_q <= ret_d; ctx_q <= ctx_d; scan_q <= scan_d;
		idx_q <= idx_d; kind_q <= kind_d; pool_q <= pool_d; req_q <= req_d;
		boff_q <= boff_d; given_q <= given_d; bzero_q <= bzero_d;
		a_q <= a_d; b_q <= b_d; ai_q <= ai_d; bi_q <= bi_d; oi_q <= oi_d;
		pv_tgt_q <= pv_tgt_d; pv_val_q <= pv_val_d;
		res_off_q <= res_off_d; old_off_q <= old_off_d; old_size_q <= old_size_d;
		sp_used_q <= sp_used_d; sp_hit_q <= sp_hit_d;
		sts_q <= sts_d; pres_q <= pres_d; moved_q <= moved_d;
	end

endmodule

// ===== hw/rtl/first_fit_block_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit
// First-fit heap allocator with coalescing over per-pool segment tables.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel (alloc, release, resize) and each
// produces exactly one response on the m_axis channel. Registers heap_bytes
// and entries_in_use are to be written on the cfg channel only while the unit
// is idle; the unit itself does not enforce this. Either write reinitializes
// every pool to one free segment spanning the heap. One request is worked at
// a time. The segment table lives in a single RAM with registered read data;
// each table entry visited by a search is read, then evaluated, and each
// split, merge or link update adds its own table reads and writes. An
// allocation that splits runs a fit search and then a spare search; the
// worst resize runs a lookup, a fit search, a spare search and a release.
// Reset (arst_n low) restores the register defaults and the initial tables
// at once; no clearing pass is needed. The response sits in an output
// register; if the receiver stalls, the unit holds the response and waits
// with s_axis_tready low once the next result is ready.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit #(
	parameter int POOL_COUNT       = ffba_pkg::POOL_COUNT_DEF,
	parameter int ENTRIES_PER_POOL = ffba_pkg::ENTRIES_DEF,
	parameter int HEAP_ADDR_BITS   = ffba_pkg::ADDR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // request_bytes, block_offset
	input  logic [4:0]  s_axis_tuser,   // kind, pool, offset_present
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // result_offset, old_offset, copy_bytes
	output logic [3:0]  m_axis_tuser,   // status, result_present, moved
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [ffba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ffba_pkg::BYTES_W-1:0]   cfg_data
);

	localparam int AW  = HEAP_ADDR_BITS;
	localparam int EIW = $clog2(ENTRIES_PER_POOL + 1);
	localparam logic [33:0] HEAP_CAP = 34'(1) << AW;
	localparam logic [33:0] HEAP_RST = (ffba_pkg::HEAP_RESET > HEAP_CAP) ? HEAP_CAP
		: ffba_pkg::HEAP_RESET;
	localparam int EIU_RST = (ENTRIES_PER_POOL < ffba_pkg::ENTRIES_RESET_CAP)
		? ENTRIES_PER_POOL : ffba_pkg::ENTRIES_RESET_CAP;

	logic [AW:0] heap_q;
	logic [EIW-1:0] eiu_q;
	logic cfg_xfer, reinit;
	logic [33:0] cfg_ext;
	ffba_pkg::req_t req;
	ffba_pkg::rsp_t rsp, out_q;
	logic rsp_valid, rsp_ready, out_valid_q;

	assign cfg_ready = 1'b1;
	assign cfg_xfer = cfg_valid && cfg_ready;
	assign cfg_ext = 34'(cfg_data);
	assign reinit = cfg_xfer && (cfg_index == ffba_pkg::REG_HEAP_BYTES
		|| cfg_index == ffba_pkg::REG_ENTRIES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_q <= (AW + 1)'(HEAP_RST);
			eiu_q <= EIW'(EIU_RST);
		end else if (cfg_xfer) begin
			case (cfg_index)
				ffba_pkg::REG_HEAP_BYTES: begin
					if (cfg_ext < ffba_pkg::HEAP_MIN) begin
						heap_q <= (AW + 1)'(ffba_pkg::HEAP_MIN);
					end else if (cfg_ext > HEAP_CAP) begin
						heap_q <= (AW + 1)'(HEAP_CAP);
					end else begin
						heap_q <= (AW + 1)'(cfg_ext);
					end
				end
				ffba_pkg::REG_ENTRIES: begin
					if (cfg_ext < 34'(ffba_pkg::ENTRIES_MIN)) begin
						eiu_q <= EIW'(ffba_pkg::ENTRIES_MIN);
					end else if (cfg_ext > 34'(ENTRIES_PER_POOL)) begin
						eiu_q <= EIW'(ENTRIES_PER_POOL);
					end else begin
						eiu_q <= EIW'(cfg_ext);
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		req.kind = s_axis_tuser[1:0];
		req.pool = s_axis_tuser[3:2];
		req.offset_present = s_axis_tuser[4];
		req.request_bytes = s_axis_tdata[20:0];
		req.block_offset = s_axis_tdata[40:21];
	end

	ffba_core #(
		.POOL_COUNT (POOL_COUNT),
		.ENTRIES    (ENTRIES_PER_POOL),
		.AW         (AW),
		.EIW        (EIW)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.heap      (heap_q),
		.eiu       (eiu_q),
		.reinit    (reinit)
	);

	assign rsp_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rsp_ready) begin
			out_valid_q <= rsp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_ready && rsp_valid) begin
			out_q <= rsp;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {3'b000, out_q.copy_bytes, out_q.old_offset, out_q.result_offset};
	assign m_axis_tuser = {out_q.moved, out_q.result_present, out_q.status};

endmodule

// ===== hw/rtl/ffba_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_chk
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "first_fit_block_allocator_unit_defines.svh"

module ffba_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [3:0]  m_axis_tuser
);

	logic out_xfer;
	assign out_xfer = m_axis_tvalid && m_axis_tready;

	`FFBA_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`FFBA_ASSERT_NXT(a_busy_after_in, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`FFBA_ASSERT_NOW(a_status_code, clk, arst_n, out_xfer, m_axis_tuser[1:0] != 2'd3)
	`FFBA_ASSERT_NOW(a_moved_present, clk, arst_n, out_xfer && m_axis_tuser[3], m_axis_tuser[2])
	`FFBA_ASSERT_NOW(a_fail_null, clk, arst_n, out_xfer && m_axis_tuser[1:0] != 2'd0, m_axis_tuser[3:2] == 2'd0)

endmodule

bind first_fit_block_allocator_unit ffba_chk u_ffba_chk (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit block allocator unit.
// ----------------------------------------------------------------------------
// Requests are generated per phase against an in-bench segment table model,
// driven through the request stream with random gaps and checked in order
// against the response stream under random and long back-pressure. Register
// writes happen between phases once all responses are back.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int NPOOL = 4;
	localparam int NENT = 32;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 300;
	localparam logic [ffba_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [ffba_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	typedef struct {
		int unsigned off;
		int unsigned size;
		bit used;
		bit present;
		bit has_prev;
		bit has_next;
		int prev;
		int next;
	} seg_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;   // request_bytes, block_offset
	logic [4:0]  s_axis_tuser = '0;   // kind, pool, offset_present
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [63:0] m_axis_tdata;        // result_offset, old_offset, copy_bytes
	logic [3:0]  m_axis_tuser;        // status, result_present, moved
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [ffba_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [ffba_pkg::BYTES_W-1:0]   cfg_data = '0;

	seg_t        seg_tbl [NPOOL][NENT];
	int unsigned heap_sz;
	int unsigned n_entries;

	ffba_pkg::req_t req_queue[$];
	ffba_pkg::rsp_t expected_rsp[$];
	bit   quiet = 0;
	bit   req_acc = 0;
	int   send_gap = 0;
	int   rx_stall = 0;
	int   rx_hold = 0;
	bit   hold_done = 0;
	int   rsp_count = 0;
	int   mismatches = 0;
	int   idle_cycles = 0;

	first_fit_block_allocator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// ---------------- segment table model ----------------
	function automatic void init_tables();
		for (int p = 0; p < NPOOL; p++) begin
			for (int i = 0; i < NENT; i++) seg_tbl[p][i] = '{default: 0};
			seg_tbl[p][0].present = 1;
			seg_tbl[p][0].size = heap_sz;
		end
	endfunction

	function automatic int spare_slot(int p);
		for (int i = 0; i < n_entries; i++)
			if (!seg_tbl[p][i].present) return i;
		return -1;
	endfunction

	function automatic int split_seg(int p, int i, int unsigned req);
		int s;
		s = spare_slot(p);
		if (s < 0) return -1;
		seg_tbl[p][s].present = 1;
		seg_tbl[p][s].used = 0;
		seg_tbl[p][s].off = seg_tbl[p][i].off + req;
		seg_tbl[p][s].size = seg_tbl[p][i].size - req;
		seg_tbl[p][s].has_prev = 1;
		seg_tbl[p][s].prev = i;
		seg_tbl[p][s].has_next = seg_tbl[p][i].has_next;
		seg_tbl[p][s].next = seg_tbl[p][i].next;
		if (seg_tbl[p][i].has_next) seg_tbl[p][seg_tbl[p][i].next].prev = s;
		seg_tbl[p][i].has_next = 1;
		seg_tbl[p][i].next = s;
		seg_tbl[p][i].size = req;
		return s;
	endfunction

	function automatic void merge_seg(int p, int l, int r);
		seg_tbl[p][l].size += seg_tbl[p][r].size;
		seg_tbl[p][l].has_next = seg_tbl[p][r].has_next;
		seg_tbl[p][l].next = seg_tbl[p][r].next;
		if (seg_tbl[p][r].has_next) seg_tbl[p][seg_tbl[p][r].next].prev = l;
		seg_tbl[p][r] = '{default: 0};
	endfunction

	function automatic void release_seg(int p, int i);
		int n;
		seg_tbl[p][i].used = 0;
		if (seg_tbl[p][i].has_next) begin
			n = seg_tbl[p][i].next;
			if (seg_tbl[p][n].present && !seg_tbl[p][n].used) merge_seg(p, i, n);
		end
		if (seg_tbl[p][i].has_prev) begin
			n = seg_tbl[p][i].prev;
			if (seg_tbl[p][n].present && !seg_tbl[p][n].used) merge_seg(p, n, i);
		end
	endfunction

	function automatic int first_fit(int p, int unsigned req);
		int s;
		for (int i = 0; i < n_entries; i++) begin
			if (seg_tbl[p][i].present && !seg_tbl[p][i].used && seg_tbl[p][i].size >= req) begin
				if (seg_tbl[p][i].size > req) s = split_seg(p, i, req);
				seg_tbl[p][i].used = 1;
				return i;
			end
		end
		return -1;
	endfunction

	function automatic int find_used(int p, int unsigned off);
		for (int i = 0; i < n_entries; i++)
			if (seg_tbl[p][i].present && seg_tbl[p][i].used && seg_tbl[p][i].off == off)
				return i;
		return -1;
	endfunction

	function automatic int unsigned round8(int unsigned x);
		return (x + 7) & ~32'd7;
	endfunction

	function automatic ffba_pkg::rsp_t alloc_rsp(int p, int unsigned bytes);
		ffba_pkg::rsp_t o;
		int i;
		o = '0;
		if (bytes == 0) return o;
		i = first_fit(p, round8(bytes));
		if (i < 0) begin
			o.status = ffba_pkg::STS_NOFIT;
			return o;
		end
		o.result_offset = ffba_pkg::OFF_W'(seg_tbl[p][i].off);
		o.result_present = 1;
		return o;
	endfunction

	function automatic ffba_pkg::rsp_t predict_rsp(ffba_pkg::req_t r);
		ffba_pkg::rsp_t o;
		int p, i, n, s, d;
		int unsigned req, old_off, old_size;
		o = '0;
		p = r.pool;
		if (r.kind == ffba_pkg::KIND_NONE) return o;
		if (r.kind == ffba_pkg::KIND_ALLOC
				|| (r.kind == ffba_pkg::KIND_RESIZE && !r.offset_present))
			return alloc_rsp(p, r.request_bytes);
		if (!r.offset_present) return o;
		i = find_used(p, r.block_offset);
		if (i < 0) begin
			o.status = ffba_pkg::STS_NOTFOUND;
			return o;
		end
		if (r.kind == ffba_pkg::KIND_RELEASE || r.request_bytes == 0) begin
			release_seg(p, i);
			return o;
		end
		req = round8(r.request_bytes);
		o.result_present = 1;
		o.result_offset = ffba_pkg::OFF_W'(seg_tbl[p][i].off);
		if (req < seg_tbl[p][i].size) begin
			s = split_seg(p, i, req);
			if (s >= 0) release_seg(p, s);
			return o;
		end
		if (req == seg_tbl[p][i].size) return o;
		if (seg_tbl[p][i].has_next) begin
			n = seg_tbl[p][i].next;
			if (seg_tbl[p][n].present && !seg_tbl[p][n].used &&
					req <= seg_tbl[p][i].size + seg_tbl[p][n].size) begin
				merge_seg(p, i, n);
				if (req < seg_tbl[p][i].size) begin
					s = split_seg(p, i, req);
					if (s >= 0) release_seg(p, s);
				end
				return o;
			end
		end
		d = first_fit(p, req);
		if (d < 0) begin
			o = '0;
			o.status = ffba_pkg::STS_NOFIT;
			return o;
		end
		old_off = seg_tbl[p][i].off;
		old_size = seg_tbl[p][i].size;
		release_seg(p, i);
		o.result_offset = ffba_pkg::OFF_W'(seg_tbl[p][d].off);
		o.moved = 1;
		o.old_offset = ffba_pkg::OFF_W'(old_off);
		o.copy_bytes = ffba_pkg::BYTES_W'(old_size);
		return o;
	endfunction

	function automatic void apply_reg(logic [ffba_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
		if (idx == ffba_pkg::REG_HEAP_BYTES) begin
			heap_sz = val < 8 ? 8 : (val > (1 << 20) ? (1 << 20) : val);
			init_tables();
		end else if (idx == ffba_pkg::REG_ENTRIES) begin
			n_entries = val < 2 ? 2 : (val > NENT ? NENT : val);
			init_tables();
		end
	endfunction

	// ---------------- stimulus helpers ----------------
	function automatic ffba_pkg::req_t mk_req(logic [1:0] k, int p, int unsigned b,
			int unsigned off, bit pres);
		ffba_pkg::req_t r;
		r.kind = k;
		r.pool = ffba_pkg::POOL_W'(p);
		r.request_bytes = ffba_pkg::BYTES_W'(b);
		r.block_offset = ffba_pkg::OFF_W'(off);
		r.offset_present = pres;
		return r;
	endfunction

	function automatic ffba_pkg::rsp_t push_req(ffba_pkg::req_t r);
		ffba_pkg::rsp_t e;
		e = predict_rsp(r);
		req_queue.push_back(r);
		expected_rsp.push_back(e);
		return e;
	endfunction

	function automatic int unsigned rand_bytes();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 3) return 0;
		if (sel < 6) return $urandom_range(0, (1 << 21) - 1);
		if (sel < 16) return $urandom_range(1, heap_sz);
		return $urandom_range(1, heap_sz / 8 > 1 ? heap_sz / 8 : 1);
	endfunction

	function automatic int unsigned live_offset(int p);
		int live[$];
		for (int i = 0; i < n_entries; i++)
			if (seg_tbl[p][i].present && seg_tbl[p][i].used) live.push_back(i);
		if (live.size() == 0 || $urandom_range(0, 9) == 0)
			return $urandom_range(0, 7) == 0 ? $urandom_range(0, (1 << 20) - 1)
				: $urandom_range(0, heap_sz / 8) * 8;
		return seg_tbl[p][live[$urandom_range(0, live.size() - 1)]].off;
	endfunction

	function automatic void random_req();
		int sel, p;
		ffba_pkg::rsp_t e;
		sel = $urandom_range(0, 99);
		p = $urandom_range(0, NPOOL - 1);
		if (sel < 40)
			e = push_req(mk_req(ffba_pkg::KIND_ALLOC, p, rand_bytes(),
				$urandom_range(0, (1 << 20) - 1), 1'($urandom_range(0, 1))));
		else if (sel < 65)
			e = push_req(mk_req(ffba_pkg::KIND_RELEASE, p, $urandom_range(0, (1 << 21) - 1),
				live_offset(p), $urandom_range(0, 19) != 0));
		else if (sel < 92)
			e = push_req(mk_req(ffba_pkg::KIND_RESIZE, p, rand_bytes(), live_offset(p),
				$urandom_range(0, 19) != 0));
		else
			e = push_req(mk_req(ffba_pkg::KIND_W'($urandom_range(0, 3)), p,
				$urandom_range(0, (1 << 21) - 1), $urandom_range(0, (1 << 20) - 1),
				1'($urandom_range(0, 1))));
	endfunction

	task automatic drain();
		while (req_queue.size() != 0 || expected_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [ffba_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= ffba_pkg::BYTES_W'(val);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 0;
		apply_reg(idx, val);
	endtask

	task automatic run_phase(int count);
		for (int k = 0; k < count; k++) random_req();
		drain();
	endtask

	// ---------------- request driver ----------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && req_acc) void'(req_queue.pop_front());
			if (s_axis_tvalid && !req_acc) begin
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_axis_tvalid <= 0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				send_gap <= $urandom_range(0, 16);
				s_axis_tvalid <= 0;
			end else if (req_queue.size() > 0) begin
				s_axis_tvalid <= 1;
				s_axis_tdata <= {7'b0, req_queue[0].block_offset, req_queue[0].request_bytes};
				s_axis_tuser <= {req_queue[0].offset_present, req_queue[0].pool,
					req_queue[0].kind};
			end else begin
				s_axis_tvalid <= 0;
			end
		end
	end

	// ---------------- response receiver ----------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && rsp_count >= 60) begin
				hold_done <= 1;
				rx_hold <= 400;
				m_axis_tready <= 0;
			end else if (rx_hold > 0) begin
				rx_hold <= rx_hold - 1;
				m_axis_tready <= 0;
			end else if (rx_stall > 0) begin
				rx_stall <= rx_stall - 1;
				m_axis_tready <= 0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				rx_stall <= $urandom_range(0, 16);
				m_axis_tready <= 0;
			end else begin
				m_axis_tready <= 1;
			end
		end
	end

	// ---------------- monitor and watchdog ----------------
	always @(posedge clk) begin
		ffba_pkg::rsp_t got, exp_r;
		req_acc <= s_axis_tvalid && s_axis_tready;
		if (m_axis_tvalid && m_axis_tready) begin
			rsp_count <= rsp_count + 1;
			got.status = m_axis_tuser[1:0];
			got.result_present = m_axis_tuser[2];
			got.moved = m_axis_tuser[3];
			got.result_offset = m_axis_tdata[19:0];
			got.old_offset = m_axis_tdata[39:20];
			got.copy_bytes = m_axis_tdata[60:40];
			if (expected_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected response %p", got);
			end else begin
				exp_r = expected_rsp.pop_front();
				if (got !== exp_r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", exp_r, got);
				end
			end
		end
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// ---------------- test sequence ----------------
	initial begin
		ffba_pkg::rsp_t a, b, e;
		heap_sz = 65536;
		n_entries = NENT;
		init_tables();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// directed corner cases
		e = push_req(mk_req(ffba_pkg::KIND_ALLOC, 0, 0, 0, 0));
		e = push_req(mk_req(ffba_pkg::KIND_ALLOC, 1, 1, 0, 0));
		e = push_req(mk_req(ffba_pkg::KIND_ALLOC, 2, (1 << 21) - 1, (1 << 20) - 1, 1));
		e = push_req(mk_req(ffba_pkg::KIND_RELEASE, 0, 0, 0, 0));
		e = push_req(mk_req(ffba_pkg::KIND_RELEASE, 0, 0, 12345, 1));
		e = push_req(mk_req(ffba_pkg::KIND_RESIZE, 0, 24, 0, 0));
		e = push_req(mk_req(ffba_pkg::KIND_RESIZE, 0, 0, e.result_offset, 1));
		e = push_req(mk_req(ffba_pkg::KIND_NONE, 3, (1 << 21) - 1, (1 << 20) - 1, 1));
		a = push_req(mk_req(ffba_pkg::KIND_ALLOC, 3, 64, 0, 0));
		b = push_req(mk_req(ffba_pkg::KIND_ALLOC, 3, 64, 0, 0));
		e = push_req(mk_req(ffba_pkg::KIND_RESIZE, 3, 30, a.result_offset, 1));
		e = push_req(mk_req(ffba_pkg::KIND_RESIZE, 3, 64, a.result_offset, 1));
		e = push_req(mk_req(ffba_pkg::KIND_RESIZE, 3, 64, a.result_offset, 1));
		e = push_req(mk_req(ffba_pkg::KIND_RESIZE, 3, 256, a.result_offset, 1));
		e = push_req(mk_req(ffba_pkg::KIND_RESIZE, 3, 1 << 20, e.result_offset, 1));
		e = push_req(mk_req(ffba_pkg::KIND_RESIZE, 3, 1000, b.result_offset, 1));
		e = push_req(mk_req(ffba_pkg::KIND_RELEASE, 3, 0, e.result_offset, 1));
		e = push_req(mk_req(ffba_pkg::KIND_ALLOC, 1, 65536, 0, 0));
		e = push_req(mk_req(ffba_pkg::KIND_ALLOC, 2, 65536, 0, 0));
		e = push_req(mk_req(ffba_pkg::KIND_RELEASE, 2, 0, 8, 1));
		run_phase(230);

		write_reg(ffba_pkg::REG_HEAP_BYTES, 1 << 20);
		write_reg(ffba_pkg::REG_ENTRIES, 32);
		run_phase(200);

		write_reg(ffba_pkg::REG_HEAP_BYTES, 256);
		write_reg(ffba_pkg::REG_ENTRIES, 4);
		run_phase(200);

		write_reg(ffba_pkg::REG_HEAP_BYTES, 0);
		write_reg(ffba_pkg::REG_ENTRIES, 0);
		run_phase(150);

		write_reg(ffba_pkg::REG_HEAP_BYTES, (1 << 21) - 1);
		write_reg(ffba_pkg::REG_ENTRIES, 63);
		write_reg(REG_SPARE_A, 5);
		write_reg(REG_SPARE_B, 100);
		run_phase(200);

		write_reg(ffba_pkg::REG_ENTRIES, 8);
		write_reg(ffba_pkg::REG_HEAP_BYTES, 4096);
		run_phase(200);

		quiet = 1;
		write_reg(ffba_pkg::REG_HEAP_BYTES, 65536);
		write_reg(ffba_pkg::REG_ENTRIES, 16);
		run_phase(200);

		if (mismatches == 0 && expected_rsp.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
